>>> rtl/sptm_pkg.sv
// Shared types and constants for the sync pulse time message capture block.
`default_nettype none

package sptm_pkg;

    localparam int unsigned MESSAGE_BYTES_DEF = 8;
    localparam int unsigned COUNT_W           = 4;
    localparam int unsigned STAMP_W           = 32;
    localparam int unsigned TIME_W            = 64;
    localparam int unsigned BYTE_W            = 8;
    localparam int unsigned KIND_W            = 2;
    localparam int unsigned APB_ADDR_W        = 3;
    localparam int unsigned APB_DATA_W        = 32;

    localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd1150000;

    // Register index taken from paddr
    localparam logic REG_TIMEOUT_US = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_SYNC = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_POLL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [STAMP_W-1:0] timer_now;
    } item_t;

endpackage

`default_nettype wire

>>> rtl/sptm_core.sv
// Capture state and per-item update: stamp, byte assembly, timeout check and result add.
`default_nettype none

module sptm_core #(
    parameter int unsigned MessageBytes = sptm_pkg::MESSAGE_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire sptm_pkg::item_t               item,
    input  wire logic [sptm_pkg::STAMP_W-1:0]  timeout_us,
    output logic                               res_valid,
    output logic [sptm_pkg::TIME_W-1:0]        res_value
);
    import sptm_pkg::*;

    logic                armed_reg, armed_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [TIME_W-1:0]   acc_reg, acc_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STAMP_W-1:0]  elapsed;
    logic                full;

    assign elapsed   = item.timer_now - stamp_reg;
    assign full      = (count_reg == COUNT_W'(MessageBytes));
    assign res_value = acc_reg + {{(TIME_W-STAMP_W){1'b0}}, elapsed};

    always_comb
    begin
        armed_next = armed_reg;
        stamp_next = stamp_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        if (go)
        begin
            case (kind_t'(item.kind))
                KIND_SYNC:
                begin
                    stamp_next = item.timer_now;
                    count_next = '0;
                    acc_next   = '0;
                    armed_next = 1'b1;
                end
                KIND_BYTE:
                begin
                    if (armed_reg && (count_reg < COUNT_W'(MessageBytes)))
                    begin
                        acc_next   = {acc_reg[TIME_W-BYTE_W-1:0], item.byte_value};
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                KIND_POLL:
                begin
                    // timeout wins over a complete message
                    if (armed_reg)
                    begin
                        if (elapsed > timeout_us)
                            armed_next = 1'b0;
                        else if (full)
                        begin
                            res_valid  = 1'b1;
                            armed_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            stamp_reg <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            stamp_reg <= stamp_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sync_pulse_time_message_capture.sv
// Top level: input register, capture core, result register and APB timeout register.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------------------
//  input   | in        | in_valid / in_stall         | kind, byte_value, timer_now
//  result  | out       | out_valid / out_stall       | time_value
//  config  | in/out    | psel penable pwrite pready  | paddr, pwdata, prdata
//
// One item per cycle unless a held result stalls it: a transfer lands in the input
// register; when it advances the core updates its state, and a poll that finds a complete
// message within the timeout loads the result register and sets out_valid. Only a held
// result (out_valid with out_stall) stops the input register from advancing, and then
// in_stall rises. Reset clears the capture state and sets timeout_us to 1150000.
`default_nettype none

module sync_pulse_time_message_capture #(
    parameter int unsigned MessageBytes = sptm_pkg::MESSAGE_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [sptm_pkg::KIND_W-1:0]      kind,
    input  wire logic [sptm_pkg::BYTE_W-1:0]      byte_value,
    input  wire logic [sptm_pkg::STAMP_W-1:0]     timer_now,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [sptm_pkg::TIME_W-1:0]           time_value,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sptm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sptm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sptm_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import sptm_pkg::*;

    logic                 s1_valid_reg, s1_valid_next;
    item_t                s1_item_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]    out_value_reg;
    logic [STAMP_W-1:0]   timeout_reg;
    logic                 advance;
    logic                 in_fire;
    logic                 res_valid;
    logic [TIME_W-1:0]    res_value;
    logic                 reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign prdata  = (reg_idx == REG_TIMEOUT_US) ? timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (psel && penable && pwrite && pready && (reg_idx == REG_TIMEOUT_US))
            timeout_reg <= pwdata;
    end

    // advance the input register whenever the result slot is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.kind       <= kind;
            s1_item_reg.byte_value <= byte_value;
            s1_item_reg.timer_now  <= timer_now;
        end
        if (res_valid)
            out_value_reg <= res_value;
    end

    sptm_core #(
        .MessageBytes(MessageBytes)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (advance),
        .item       (s1_item_reg),
        .timeout_us (timeout_reg),
        .res_valid  (res_valid),
        .res_value  (res_value)
    );

    assign out_valid  = out_valid_reg;
    assign time_value = out_value_reg;

endmodule

`default_nettype wire
